### hdl/cscan_pkg.sv
// Shared widths, reset values, sequencer states and control structs of the C-SCAN scheduler.
`timescale 1ns / 1ps

package cscan_pkg;

   localparam int CYL_W  = 16;
   localparam int SEEK_W = 18;

   localparam logic [CYL_W-1:0] CYL_MAX_RESET = 16'd199;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_PICK,
      ST_EMIT
   } state_type;

   // controls from the sequencer to the select unit
   typedef struct packed {
      logic start_pass;
      logic eval;
      logic wrap;
      logic mark;
      logic clear_flags;
   } sel_ctrl_type;

endpackage

### hdl/cscan_if.sv
// Request and response channel interfaces of the C-SCAN scheduler.
`timescale 1ns / 1ps

interface cscan_req_if;
   import cscan_pkg::*;

   logic             valid;
   logic             ready;
   logic [CYL_W-1:0] request_cylinder;
   logic [CYL_W-1:0] head_position;
   logic             last;

   modport source (output valid, output request_cylinder, output head_position,
                   output last, input ready);
   modport sink   (input valid, input request_cylinder, input head_position,
                   input last, output ready);
endinterface

interface cscan_rsp_if;
   import cscan_pkg::*;

   logic              valid;
   logic              ready;
   logic [CYL_W-1:0]  served_cylinder;
   logic [SEEK_W-1:0] seek_distance;
   logic [SEEK_W-1:0] total_movement;
   logic              last_served;

   modport source (output valid, output served_cylinder, output seek_distance,
                   output total_movement, output last_served, input ready);
   modport sink   (input valid, input served_cylinder, input seek_distance,
                   input total_movement, input last_served, output ready);
endinterface

### hdl/cscan_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cscan_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/cscan_select.sv
// Shared compare unit: clamps each stored word, tracks the smallest eligible one, keeps served flags.
`timescale 1ns / 1ps

module cscan_select #(
   parameter int REQUESTS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cscan_pkg::sel_ctrl_type     ctrl,
   input  logic [$clog2(REQUESTS)-1:0] tag,
   input  logic [cscan_pkg::CYL_W-1:0] rd_data,
   input  logic [cscan_pkg::CYL_W-1:0] head,
   input  logic [cscan_pkg::CYL_W-1:0] cylinder_max,
   output logic                        found,
   output logic [cscan_pkg::CYL_W-1:0] best
);
   import cscan_pkg::*;

   localparam int IDX_W = $clog2(REQUESTS);

   logic [REQUESTS-1:0] served_ff, served_in;
   logic                found_ff, found_in;
   logic [CYL_W-1:0]    best_ff, best_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [CYL_W-1:0]    value;
   logic                cand;

   // saturate the stored word and test it against the running minimum
   always_comb begin
      value = (rd_data > cylinder_max) ? cylinder_max : rd_data;
      cand  = ctrl.eval && !served_ff[tag] && (ctrl.wrap || (value >= head)) &&
              (!found_ff || (value < best_ff));
   end

   // update minimum and served flags
   always_comb begin
      found_in    = found_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      served_in   = served_ff;
      if (ctrl.start_pass) begin
         found_in = 1'b0;
      end else if (cand) begin
         found_in    = 1'b1;
         best_in     = value;
         best_idx_in = tag;
      end
      if (ctrl.clear_flags) begin
         served_in = '0;
      end else if (ctrl.mark) begin
         served_in[best_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         served_ff <= '0;
         found_ff  <= 1'b0;
      end else begin
         served_ff <= served_in;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
   end

   assign found = found_ff;
   assign best  = best_ff;

endmodule

### hdl/c_scan_disk_scheduler_top.sv
// Top level of the C-SCAN disk scheduler: load, sequencer, seek arithmetic and result register.
//
//  channel   dir  handshake          payload
//  req_chan  in   valid/ready        request_cylinder, head_position, last
//  rsp_chan  out  valid/ready        served_cylinder, seek_distance, total_movement, last_served
//  csr       in   csr_wr_en          csr_wr_data (cylinder_max)
//
// Loading accepts one word per cycle. After the word marked last, each result costs one scan
// of the n stored requests through the request RAM read port, then the drain, pick and emit
// states; the switch to the wrapped half of the sweep costs one more scan.
// Reset is synchronous; cylinder_max returns to 199 and no RAM clearing pass is run.
// req_chan is not ready from the last word until the final result is taken; a stalled
// result holds the sequencer in place.
`timescale 1ns / 1ps

module c_scan_disk_scheduler_top #(
   parameter int REQUESTS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   cscan_req_if.sink                   req_chan,
   cscan_rsp_if.source                 rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [cscan_pkg::CYL_W-1:0] csr_wr_data
);
   import cscan_pkg::*;

   localparam int IDX_W = $clog2(REQUESTS);
   localparam int CNT_W = $clog2(REQUESTS + 1);

   state_type         state_ff, state_in;
   logic [CYL_W-1:0]  cmax_ff, cmax_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  served_cnt_ff, served_cnt_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]  rd_tag_ff, rd_tag_in;
   logic [CYL_W-1:0]  head_ff, head_in;
   logic [CYL_W-1:0]  pos_ff, pos_in;
   logic [SEEK_W-1:0] total_ff, total_in;
   logic              wrap_ff, wrap_in;
   logic              first_wrap_ff, first_wrap_in;
   logic [CYL_W-1:0]  out_cyl_ff, out_cyl_in;
   logic [SEEK_W-1:0] out_seek_ff, out_seek_in;
   logic [SEEK_W-1:0] out_total_ff, out_total_in;
   logic              out_fin_ff, out_fin_in;

   sel_ctrl_type      sel_ctrl;
   logic              found;
   logic [CYL_W-1:0]  best;
   logic [CYL_W-1:0]  rd_data;
   logic              req_acc, rsp_acc, store_en, issue, last_issue, start_run, load_result;
   logic [CYL_W-1:0]  head_clamp;
   logic [SEEK_W-1:0] seek;

   assign req_acc    = req_chan.valid && req_chan.ready;
   assign rsp_acc    = rsp_chan.valid && rsp_chan.ready;
   assign store_en   = req_acc && (count_ff < CNT_W'(REQUESTS));
   assign start_run  = req_acc && req_chan.last;
   assign last_issue = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   assign head_clamp = (req_chan.head_position > cmax_ff) ? cmax_ff : req_chan.head_position;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (start_run) state_in = ST_SCAN;
         ST_SCAN:  if (last_issue) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_PICK;
         ST_PICK: begin
            if (found) begin
               state_in = ST_EMIT;
            end else if (!wrap_ff) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_acc) begin
               state_in = out_fin_ff ? ST_IDLE : ST_SCAN;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_chan.ready       = 1'b0;
      rsp_chan.valid       = 1'b0;
      issue                = 1'b0;
      load_result          = 1'b0;
      sel_ctrl.clear_flags = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready       = 1'b1;
            sel_ctrl.clear_flags = start_run;
         end
         ST_SCAN:  issue = 1'b1;
         ST_DRAIN: issue = 1'b0;
         ST_PICK:  load_result = found;
         ST_EMIT:  rsp_chan.valid = 1'b1;
         default:  issue = 1'b0;
      endcase
      sel_ctrl.start_pass = (state_ff != ST_SCAN) && (state_in == ST_SCAN);
      sel_ctrl.eval       = rd_pend_ff;
      sel_ctrl.wrap       = wrap_ff;
      sel_ctrl.mark       = load_result;
   end

   // seek arithmetic: straight step, or run to the end plus the return seek
   always_comb begin
      if (wrap_ff && first_wrap_ff) begin
         seek = SEEK_W'(cmax_ff - pos_ff) + SEEK_W'(cmax_ff) + SEEK_W'(best);
      end else begin
         seek = SEEK_W'(best - pos_ff);
      end
   end

   // datapath registers
   always_comb begin
      cmax_in       = csr_wr_en ? csr_wr_data : cmax_ff;
      count_in      = count_ff;
      served_cnt_in = served_cnt_ff;
      idx_in        = idx_ff;
      rd_pend_in    = issue;
      rd_tag_in     = idx_ff;
      head_in       = head_ff;
      pos_in        = pos_ff;
      total_in      = total_ff;
      wrap_in       = wrap_ff;
      first_wrap_in = first_wrap_ff;
      out_cyl_in    = out_cyl_ff;
      out_seek_in   = out_seek_ff;
      out_total_in  = out_total_ff;
      out_fin_in    = out_fin_ff;

      if (store_en) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (start_run) begin
         head_in       = head_clamp;
         pos_in        = head_clamp;
         total_in      = '0;
         wrap_in       = 1'b0;
         first_wrap_in = 1'b1;
         served_cnt_in = '0;
      end
      // advance the scan index, restart it at each pass
      if (sel_ctrl.start_pass) begin
         idx_in = '0;
      end else if (issue) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      // no candidate at or above the head: go to the wrapped half; none after the wrap: drop the set
      if ((state_ff == ST_PICK) && !found) begin
         wrap_in = 1'b1;
         if (wrap_ff) begin
            count_in = '0;
         end
      end
      if (load_result) begin
         out_cyl_in    = best;
         out_seek_in   = seek;
         out_total_in  = total_ff + seek;
         out_fin_in    = (served_cnt_ff + CNT_W'(1)) == count_ff;
         total_in      = total_ff + seek;
         pos_in        = best;
         served_cnt_in = served_cnt_ff + CNT_W'(1);
         if (wrap_ff) begin
            first_wrap_in = 1'b0;
         end
      end
      // drop the set once the final word is taken
      if (rsp_acc && out_fin_ff) begin
         count_in = '0;
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cmax_ff       <= CYL_MAX_RESET;
         count_ff      <= '0;
         served_cnt_ff <= '0;
         idx_ff        <= '0;
         rd_pend_ff    <= 1'b0;
         head_ff       <= '0;
         pos_ff        <= '0;
         total_ff      <= '0;
         wrap_ff       <= 1'b0;
         first_wrap_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cmax_ff       <= cmax_in;
         count_ff      <= count_in;
         served_cnt_ff <= served_cnt_in;
         idx_ff        <= idx_in;
         rd_pend_ff    <= rd_pend_in;
         head_ff       <= head_in;
         pos_ff        <= pos_in;
         total_ff      <= total_in;
         wrap_ff       <= wrap_in;
         first_wrap_ff <= first_wrap_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_tag_ff    <= rd_tag_in;
      out_cyl_ff   <= out_cyl_in;
      out_seek_ff  <= out_seek_in;
      out_total_ff <= out_total_in;
      out_fin_ff   <= out_fin_in;
   end

   assign rsp_chan.served_cylinder = out_cyl_ff;
   assign rsp_chan.seek_distance   = out_seek_ff;
   assign rsp_chan.total_movement  = out_total_ff;
   assign rsp_chan.last_served     = out_fin_ff;

   cscan_ram #(
      .WIDTH (CYL_W),
      .DEPTH (REQUESTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_chan.request_cylinder),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   cscan_select #(
      .REQUESTS (REQUESTS)
   ) u_select (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (sel_ctrl),
      .tag          (rd_tag_ff),
      .rd_data      (rd_data),
      .head         (head_ff),
      .cylinder_max (cmax_ff),
      .found        (found),
      .best         (best)
   );

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(REQUESTS))
      else $error("request count above store depth");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("load and result active together");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_chan.last_served) |=> (count_ff == '0) && (state_ff == ST_IDLE))
      else $error("set not dropped after final word");

   a_served_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (served_cnt_ff <= count_ff) && (served_cnt_ff != '0))
      else $error("served count out of range");
`endif

endmodule

### dv/cscan_order_checker.sv
// Checker of the C-SCAN scheduler: watches both channels, predicts the service order and compares.
`timescale 1ns / 1ps

module cscan_order_checker #(
   parameter int REQUESTS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   cscan_req_if                        req_mon,
   cscan_rsp_if                        rsp_mon,
   input  logic                        csr_wr_en,
   input  logic [cscan_pkg::CYL_W-1:0] csr_wr_data,
   output int                          fail_count,
   output int                          pending_results
);
   import cscan_pkg::*;

   typedef struct packed {
      logic [CYL_W-1:0]  cylinder;
      logic [SEEK_W-1:0] seek;
      logic [SEEK_W-1:0] total;
      logic              closes_run;
   } served_type;

   logic [CYL_W-1:0] cyl_limit;
   logic [CYL_W-1:0] pending_cyl [REQUESTS];
   int               stored;
   int               failures = 0;
   served_type       service_q [$];

   function automatic served_type sched_entry(int cyl, int seek, int total, bit fin);
      served_type e;
      e.cylinder   = cyl[CYL_W-1:0];
      e.seek       = seek[SEEK_W-1:0];
      e.total      = total[SEEK_W-1:0];
      e.closes_run = fin;
      return e;
   endfunction

   // sort the stored requests, sweep upward from the head, wrap to 0 for the rest
   task automatic plan_cscan_sweep(input logic [CYL_W-1:0] head_raw);
      int order [REQUESTS];
      int count, split, pos, v, i, j, seek, total, limit;
      limit = int'(cyl_limit);
      count = stored;
      pos = (head_raw > cyl_limit) ? limit : int'(head_raw);
      for (i = 0; i < count; i++) begin
         v = (pending_cyl[i] > cyl_limit) ? limit : int'(pending_cyl[i]);
         j = i;
         while (j > 0 && order[j-1] > v) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = v;
      end
      split = 0;
      while (split < count && order[split] < pos)
         split++;
      total = 0;
      for (i = split; i < count; i++) begin
         seek = order[i] - pos;
         total += seek;
         service_q.push_back(sched_entry(order[i], seek, total,
                                         (i + 1 == count) && (split == 0)));
         pos = order[i];
      end
      // first one after the wrap pays the run to the end and the return seek
      for (i = 0; i < split; i++) begin
         if (i == 0)
            seek = (limit - pos) + limit + order[0];
         else
            seek = order[i] - pos;
         total += seek;
         service_q.push_back(sched_entry(order[i], seek, total, i + 1 == split));
         pos = order[i];
      end
   endtask

   always @(posedge clock) begin
      served_type got;
      served_type want;
      if (reset) begin
         cyl_limit = CYL_MAX_RESET;
         stored = 0;
         service_q.delete();
      end else begin
         if (csr_wr_en)
            cyl_limit = csr_wr_data;

         // compare each result word with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.cylinder   = rsp_mon.served_cylinder;
            got.seek       = rsp_mon.seek_distance;
            got.total      = rsp_mon.total_movement;
            got.closes_run = rsp_mon.last_served;
            if (service_q.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected result: cyl %0d seek %0d total %0d last %0b",
                           got.cylinder, got.seek, got.total, got.closes_run);
            end else begin
               want = service_q.pop_front();
               if (got.cylinder !== want.cylinder || got.seek !== want.seek ||
                   got.total !== want.total || got.closes_run !== want.closes_run) begin
                  failures++;
                  if (failures <= 10)
                     $display("mismatch: expected cyl %0d seek %0d total %0d last %0b, %s",
                              want.cylinder, want.seek, want.total, want.closes_run,
                              $sformatf("got cyl %0d seek %0d total %0d last %0b",
                                        got.cylinder, got.seek, got.total,
                                        got.closes_run));
               end
            end
         end

         // store the request word; drop it once the store is full
         if (req_mon.valid && req_mon.ready) begin
            if (stored < REQUESTS) begin
               pending_cyl[stored] = req_mon.request_cylinder;
               stored++;
            end
            if (req_mon.last) begin
               plan_cscan_sweep(req_mon.head_position);
               stored = 0;
            end
         end
      end
      fail_count      <= failures;
      pending_results <= service_q.size();
   end

endmodule

### dv/testbench.sv
// Testbench top of the C-SCAN scheduler: clock, reset, request stimulus, result stalls, verdict.
`timescale 1ns / 1ps

module testbench;
   import cscan_pkg::*;

   localparam int REQUESTS = 8;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CYL_W-1:0] csr_wr_data;
   int               fail_count;
   int               pending_results;

   int               burst_left;
   bit               gaps_on;
   logic [CYL_W-1:0] cyl_max_now;

   cscan_req_if req_chan ();
   cscan_rsp_if rsp_chan ();

   c_scan_disk_scheduler_top #(.REQUESTS(REQUESTS)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   cscan_order_checker #(.REQUESTS(REQUESTS)) order_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // end the run if it hangs
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // offer one request word, in bursts with random gaps when enabled, and hold it until taken
   task automatic send_word(input logic [CYL_W-1:0] cyl, input logic [CYL_W-1:0] head,
                            input logic fin);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = 0;
         if (gaps_on)
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_chan.valid            <= 1'b1;
      req_chan.request_cylinder <= cyl;
      req_chan.head_position    <= head;
      req_chan.last             <= fin;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      burst_left--;
   endtask

   // drop valid and wait until every predicted result has come back
   task automatic settle_block();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_cylinder_max(input logic [CYL_W-1:0] value);
      settle_block();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cyl_max_now = value;
   endtask

   // mostly in range, some at the edges, some anywhere in 16 bits
   function automatic logic [CYL_W-1:0] pick_cylinder();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 5)
         return CYL_W'($urandom_range(0, int'(cyl_max_now)));
      if (roll == 5)
         return '0;
      if (roll == 6)
         return cyl_max_now;
      if (roll == 7)
         return cyl_max_now + 1'b1;
      return CYL_W'($urandom_range(0, 65535));
   endfunction

   // random request sets; a few overfill the store
   task automatic random_sets(input int word_goal);
      int words, n, i;
      words = 0;
      while (words < word_goal) begin
         n = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
         for (i = 0; i < n; i++)
            send_word(pick_cylinder(), pick_cylinder(), i == n - 1);
         words += (n > REQUESTS) ? REQUESTS : n;
      end
   endtask

   // result side: duty cycle changes now and then, one long hold-off
   initial begin
      int  taken, duty, span;
      bit  long_hold_done;
      taken = 0;
      duty = 100;
      span = 0;
      long_hold_done = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            taken++;
         if (span == 0) begin
            span = $urandom_range(20, 80);
            case ($urandom_range(0, 3))
               0: duty = 100;
               1: duty = 70;
               2: duty = 35;
               default: duty = 10;
            endcase
         end
         span--;
         if (taken >= 30 && !long_hold_done) begin
            long_hold_done = 1;
            rsp_chan.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else begin
            rsp_chan.ready <= ($urandom_range(1, 100) <= duty);
         end
      end
   end

   initial begin
      int i;
      reset                     <= 1'b1;
      req_chan.valid            <= 1'b0;
      req_chan.request_cylinder <= '0;
      req_chan.head_position    <= '0;
      req_chan.last             <= 1'b0;
      csr_wr_en                 <= 1'b0;
      csr_wr_data               <= '0;
      burst_left  = 0;
      gaps_on     = 1;
      cyl_max_now = CYL_MAX_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed sets at the reset limit
      send_word(16'd0, 16'd0, 1'b1);
      send_word(16'd60, 16'd0, 1'b0);
      send_word(16'd90, 16'd0, 1'b0);
      send_word(16'd75, 16'd30, 1'b1);
      send_word(16'd120, 16'd0, 1'b0);
      send_word(16'd40, 16'd0, 1'b0);
      send_word(16'd199, 16'd50, 1'b1);
      send_word(16'd10, 16'd0, 1'b0);
      send_word(16'd20, 16'd150, 1'b1);
      send_word(16'hFFFF, 16'd0, 1'b0);
      send_word(16'd300, 16'hFFFF, 1'b1);
      // overfill: the last three words are dropped, the run still starts
      for (i = 0; i < 11; i++)
         send_word(CYL_W'($urandom_range(0, 199)), CYL_W'($urandom_range(0, 199)), i == 10);

      set_cylinder_max(16'd1);
      random_sets(24);
      set_cylinder_max(16'hFFFF);
      gaps_on = 0;
      random_sets(24);
      gaps_on = 1;
      set_cylinder_max(CYL_W'($urandom_range(2, 65534)));
      random_sets(24);
      set_cylinder_max(CYL_MAX_RESET);
      random_sets(24);

      settle_block();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### files.f
hdl/cscan_pkg.sv
hdl/cscan_if.sv
hdl/cscan_ram.sv
hdl/cscan_select.sv
hdl/c_scan_disk_scheduler_top.sv
dv/cscan_order_checker.sv
dv/testbench.sv
